/* rtl/core/sdf_pkg.sv */
// shared constants for the signed decimal formatter
package sdf_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;

    localparam logic [5:0] ASCII_ZERO  = 6'd48;
    localparam logic [5:0] ASCII_MINUS = 6'd45;

    localparam logic [3:0] BCD_LIMIT  = 4'd5;
    localparam logic [3:0] BCD_ADJUST = 4'd3;

    localparam int LOG10_2_NUM = 30103;
    localparam int LOG10_2_DEN = 100000;

endpackage

/* rtl/core/sdf_convert.sv */
// bit-serial double dabble: signed binary to sign and bcd digits
module sdf_convert #(
    parameter int VALUE_BITS = sdf_pkg::VALUE_BITS_DEFAULT,
    parameter int DIGITS     = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [VALUE_BITS-1:0]   i_value,
    output logic                    o_done,
    input  logic                    i_take,
    output logic                    o_neg,
    output logic [DIGITS*4-1:0]     o_bcd
);

    localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [3:0] BCD_LIMIT_L  = sdf_pkg::BCD_LIMIT;
    localparam logic [3:0] BCD_ADJUST_L = sdf_pkg::BCD_ADJUST;

    logic [1:0]             r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [VALUE_BITS-1:0]  r_mag, n_mag;
    logic [DIGITS*4-1:0]    r_bcd, n_bcd;
    logic                   r_neg, n_neg;
    logic [DIGITS*4-1:0]    adj;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= BCD_LIMIT_L) begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4] + BCD_ADJUST_L;
            end else begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mag   = r_mag;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_value[VALUE_BITS-1];
                    n_mag   = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
                    n_bcd   = '0;
                    n_cnt   = CW'(VALUE_BITS - 1);
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_bcd = {adj[DIGITS*4-2:0], r_mag[VALUE_BITS-1]};
                n_mag = r_mag << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_mag <= n_mag;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_done  = (r_state == ST_DONE);
    assign o_neg   = r_neg;
    assign o_bcd   = r_bcd;

endmodule

/* rtl/core/sdf_emit.sv */
// character emitter: sign, leading zero skip, one digit per transaction
module sdf_emit #(
    parameter int DIGITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    output logic                    o_load_ready,
    input  logic                    i_neg,
    input  logic [DIGITS*4-1:0]     i_bcd,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [5:0]              o_character,
    output logic                    o_last
);

    localparam int LW = $clog2(DIGITS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SKIP  = 2'd1;
    localparam logic [1:0] ST_SIGN  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [DIGITS*4-1:0]    r_bcd, n_bcd;
    logic [LW-1:0]          r_left, n_left;
    logic                   r_neg, n_neg;
    logic                   r_valid, n_valid;
    logic [5:0]             r_char, n_char;
    logic                   r_last, n_last;
    logic [3:0]             top_digit;
    logic                   slot_free;

    assign top_digit = r_bcd[DIGITS*4-1 -: 4];
    assign slot_free = !r_valid || i_ready;

    always_comb begin
        n_state = r_state;
        n_bcd   = r_bcd;
        n_left  = r_left;
        n_neg   = r_neg;
        n_valid = r_valid && !i_ready;
        n_char  = r_char;
        n_last  = r_last;
        case (r_state)
            ST_IDLE: begin
                if (i_load) begin
                    n_bcd   = i_bcd;
                    n_neg   = i_neg;
                    n_left  = LW'(DIGITS);
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit == 4'd0 && r_left > LW'(1)) begin
                    n_bcd  = {r_bcd[DIGITS*4-5:0], 4'd0};
                    n_left = r_left - 1'b1;
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    n_valid = 1'b1;
                    n_char  = sdf_pkg::ASCII_MINUS;
                    n_last  = 1'b0;
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (slot_free) begin
                    n_valid = 1'b1;
                    n_char  = sdf_pkg::ASCII_ZERO + {2'b00, top_digit};
                    n_last  = (r_left == LW'(1));
                    n_bcd   = {r_bcd[DIGITS*4-5:0], 4'd0};
                    n_left  = r_left - 1'b1;
                    if (r_left == LW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_bcd  <= n_bcd;
        r_left <= n_left;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_load_ready = (r_state == ST_IDLE);
    assign o_valid      = r_valid;
    assign o_character  = r_char;
    assign o_last       = r_last;

endmodule

/* rtl/core/signed_decimal_formatter_top.sv */
// top level of the signed decimal formatter
// Each accepted transaction carries one two's complement value of VALUE_BITS bits and yields
// its decimal text as ASCII characters, most significant first: a leading '-' for negative
// values, a single '0' for zero, o_last high on the final character; the most negative value
// converts correctly. A conversion runs in the bit-serial double dabble shifter, which
// consumes one magnitude bit per cycle; once the leading zeros have been skipped, the
// characters are handed out at up to one per cycle unless the output side stalls, while the
// next value converts.
module signed_decimal_formatter_top #(
    parameter int VALUE_BITS = sdf_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [VALUE_BITS-1:0]   i_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [5:0]              o_character,
    output logic                    o_last
);

    localparam int DIGITS =
        ((VALUE_BITS - 1) * sdf_pkg::LOG10_2_NUM) / sdf_pkg::LOG10_2_DEN + 1;

    logic                   conv_done;
    logic                   emit_ready;
    logic                   handoff;
    logic                   conv_neg;
    logic [DIGITS*4-1:0]    conv_bcd;

    assign handoff = conv_done && emit_ready;

    sdf_convert #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_done  (conv_done),
        .i_take  (handoff),
        .o_neg   (conv_neg),
        .o_bcd   (conv_bcd)
    );

    sdf_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (handoff),
        .o_load_ready (emit_ready),
        .i_neg        (conv_neg),
        .i_bcd        (conv_bcd),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_character  (o_character),
        .o_last       (o_last)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while a conversion is running");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == sdf_pkg::ASCII_MINUS ||
                     (o_character >= sdf_pkg::ASCII_ZERO &&
                      o_character <= sdf_pkg::ASCII_ZERO + 6'd9)))
        else $error("illegal output character");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_character == sdf_pkg::ASCII_MINUS) |-> !o_last)
        else $error("minus sign flagged as last character");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the signed decimal formatter, driving values and checking text
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W            = sdf_pkg::VALUE_BITS_DEFAULT;
    localparam int DECIMAL_BASE = 10;
    localparam int RANDOM_ITEMS = 88;
    localparam int TAIL_CYCLES  = 2 * (W + 2) + 16;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [5:0] ch;
        logic       last;
    } t_text_char;

    typedef struct {
        logic [W-1:0] value;
        bit           drain;
    } t_pending_value;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic [W-1:0] i_value = '0;
    logic         i_ready = 1'b0;
    logic         o_ready;
    logic         o_valid;
    logic [5:0]   o_character;
    logic         o_last;

    t_pending_value value_q[$];
    t_text_char     text_q[$];

    bit in_taken    = 1'b0;
    bit out_taken   = 1'b0;
    int send_wait   = 0;
    int recv_wait   = 0;
    int sent_count  = 0;
    int chars_seen  = 0;
    int fault_count = 0;

    signed_decimal_formatter_top #(
        .VALUE_BITS (W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void append_decimal_text(logic [W-1:0] v);
        logic [W:0] mag;
        logic [3:0] digits[$];
        t_text_char c;
        mag = v[W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
        do begin
            digits.push_front(4'(mag % DECIMAL_BASE));
            mag = mag / DECIMAL_BASE;
        end while (mag != 0);
        if (v[W-1]) begin
            c.ch   = sdf_pkg::ASCII_MINUS;
            c.last = 1'b0;
            text_q.push_back(c);
        end
        foreach (digits[i]) begin
            c.ch   = sdf_pkg::ASCII_ZERO + 6'(digits[i]);
            c.last = (i == digits.size() - 1);
            text_q.push_back(c);
        end
    endfunction

    function automatic logic [W-1:0] random_value();
        longint unsigned lo;
        longint unsigned hi;
        int              ndig;
        logic [W-1:0]    v;
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom;
        end else begin
            ndig = $urandom_range(1, 10);
            lo   = 1;
            repeat (ndig - 1) lo = lo * DECIMAL_BASE;
            hi   = lo * DECIMAL_BASE - 1;
            if (ndig == 1) lo = 0;
            if (hi > 64'd2147483647) hi = 64'd2147483647;
            v = $urandom_range(32'(hi), 32'(lo));
            if ($urandom_range(0, 1) == 1) v = -v;
        end
        return v;
    endfunction

    // sender: one value per transaction, random gaps, occasional drain
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                in_taken = 1'b0;
                if (send_wait > 0) begin
                    send_wait = send_wait - 1;
                    i_valid <= 1'b0;
                end else if (value_q.size() != 0 &&
                             !(value_q[0].drain && text_q.size() != 0)) begin
                    i_valid    <= 1'b1;
                    i_value    <= value_q[0].value;
                    value_q.pop_front();
                    sent_count = sent_count + 1;
                    send_wait  = (sent_count >= 60 && sent_count < 85) ? 0
                                 : $urandom_range(0, 10);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall after each character, with stall-free stretches
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) begin
                out_taken = 1'b0;
                recv_wait = (chars_seen % 150 < 40) ? 0 : $urandom_range(0, 10);
            end
            if (recv_wait > 0) begin
                recv_wait = recv_wait - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                in_taken = 1'b1;
                append_decimal_text(i_value);
            end
            if (o_valid && i_ready) begin
                out_taken  = 1'b1;
                chars_seen = chars_seen + 1;
                if (text_q.size() == 0) begin
                    fault_count = fault_count + 1;
                    if (fault_count <= REPORT_LIMIT)
                        $display("unexpected character %0d last %0b", o_character, o_last);
                end else begin
                    if (o_character !== text_q[0].ch || o_last !== text_q[0].last) begin
                        fault_count = fault_count + 1;
                        if (fault_count <= REPORT_LIMIT)
                            $display("character %0d: expected %0d last %0b, got %0d last %0b",
                                     chars_seen, text_q[0].ch, text_q[0].last,
                                     o_character, o_last);
                    end
                    text_q.pop_front();
                end
            end
        end
    end

    initial begin
        logic [W-1:0]   directed[22] = '{
            32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
            32'sd100, 32'sd2147483647, 32'h8000_0000, -32'sd2147483647,
            32'sd1000000000, 32'sd999999999, -32'sd1000000000, 32'sd1234567890,
            -32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
            32'hFFFF_0000, 32'sd42};
        t_pending_value p;
        foreach (directed[i]) begin
            p.value = directed[i];
            p.drain = 1'b0;
            value_q.push_back(p);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            p.value = random_value();
            p.drain = (i == 0) || ($urandom_range(0, 19) == 0);
            value_q.push_back(p);
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (value_q.size() != 0 || i_valid) @(posedge i_clk);
        while (text_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && text_q.size() == 0) begin
            $display("signed_decimal_formatter_top regression: pass");
        end else begin
            $display("signed_decimal_formatter_top regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("signed_decimal_formatter_top regression: fail");
        $finish;
    end

endmodule
